// ----- hdl/ffa_pkg.sv -----
// Shared constants, codes and types of the first-fit block allocator.
// Used by the allocator top level, its port checker, the result checker and the testbench.
`default_nettype none

package ffa_pkg;

  // Pool geometry.
  localparam int POOL_WORDS = 1024;
  localparam int WORD_BYTES = 8;
  localparam int ADDR_W     = $clog2(POOL_WORDS);
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int LEN_W      = ADDR_W + 1;
  localparam int HDR_W      = LEN_W + 1;

  // Field widths of the command and result ports.
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int BYTES_W  = 14;
  localparam int OFF_W    = 13;
  localparam int WORDS_W  = BYTES_W - WORD_SHIFT;
  localparam int REQ_W    = BYTES_W - WORD_SHIFT + 1;
  localparam int CMP_W    = REQ_W + 1;

  // Register port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_POOL_BYTES = '0;
  localparam logic [BYTES_W-1:0] POOL_BYTES_RESET = BYTES_W'(POOL_WORDS * WORD_BYTES);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // One block header: allocated mark and block length in words.
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } hdr_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_FWALK = 6'b000100,
    S_SPLIT = 6'b001000,
    S_FMT0  = 6'b010000,
    S_FMT1  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: command port, register port,
// walk sequencer and header RAM. Depends on ffa_pkg and ffa_ram.
`default_nettype none

// How to use this block.
// A command transaction is accepted at a rising edge with start high and busy low;
// kind selects allocate, free or query, with request_bytes and block_offset as
// operands. Each command gives exactly one result transaction: done is high for
// one cycle with status, payload_offset and largest_free_bytes valid. The receiver
// cannot stall; the result is taken in the cycle it is shown.
// Block headers live in a 1024-entry RAM with one write and one registered read
// port. The sequencer visits one header per cycle, issuing the next read address
// straight from the header just returned. An allocate walks the headers from the
// start of the pool to the first fit or the end marker, a query to the end marker;
// an allocate that splits a block then writes the remainder header in S_SPLIT.
// A free walks the headers up to the named block. A free with a malformed offset
// and the unused kind answer straight from idle, without a walk.
// Reset and every write of pool_bytes format the pool: busy stays high through
// S_FMT0 and S_FMT1, which write the first free header and the end marker. Only
// headers on the chain are ever read, so no clearing pass is needed. pool_bytes is
// read back over the register port, which is always ready.

module first_fit_block_allocator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [ffa_pkg::KIND_W-1:0]         kind,
  input  wire logic [ffa_pkg::BYTES_W-1:0]        request_bytes,
  input  wire logic [ffa_pkg::OFF_W-1:0]          block_offset,
  // Result channel
  output logic                                    done,
  output logic [ffa_pkg::STATUS_W-1:0]            status,
  output logic [ffa_pkg::OFF_W-1:0]               payload_offset,
  output logic [ffa_pkg::BYTES_W-1:0]             largest_free_bytes,
  // Register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ffa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [ffa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ffa_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  import ffa_pkg::*;

  // Control state.
  state_t state, state_next;
  logic   in_run, in_run_next;

  // Configuration.
  logic [BYTES_W-1:0] pool_bytes;
  logic [ADDR_W-1:0]  end_word, end_word_next;
  logic [WORDS_W-1:0] words_raw, words_clamped;
  logic               cfg_wr;

  // Walk registers.
  logic [PTR_W-1:0]  pos, pos_next;
  logic [ADDR_W-1:0] run_start, run_start_next;
  logic [LEN_W-1:0]  run, run_next;
  logic [LEN_W-1:0]  best, best_next;
  logic [REQ_W-1:0]  req, req_next;
  logic [ADDR_W-1:0] target, target_next;
  logic [KIND_W-1:0] op_kind, op_kind_next;
  logic [ADDR_W-1:0] split_addr, split_addr_next;
  logic [LEN_W-1:0]  split_len, split_len_next;

  // Result registers.
  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [OFF_W-1:0]    payload_offset_next;
  logic [BYTES_W-1:0]  largest_free_bytes_next;

  // Header RAM ports.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  hdr_t              wr_hdr, rd_hdr;
  logic [HDR_W-1:0]  rd_data;

  // Datapath terms of the header just read.
  logic [LEN_W-1:0]   step;
  logic [PTR_W-1:0]   npos;
  logic [LEN_W-1:0]   acc_run;
  logic [ADDR_W-1:0]  acc_start;
  logic [LEN_W-1:0]   best_closed;
  logic               fit, split, walk_end;
  logic [BYTES_W:0]   req_sum;
  logic [PTR_W-1:0]   pay_words;
  logic [LEN_W-1:0]   largest_words;

  ffa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (POOL_WORDS)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_hdr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_hdr = hdr_t'(rd_data);
  assign busy   = (state != S_IDLE);

  // Register port: one register, read back as written.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[CFG_ADDR_W-1:2] == REG_POOL_BYTES);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_POOL_BYTES) ? CFG_DATA_W'(pool_bytes) : '0;

  // The pool holds at least two words and at most the size of the RAM.
  assign words_raw = pwdata[BYTES_W-1:WORD_SHIFT];
  always_comb begin
    words_clamped = words_raw;
    if (words_raw < WORDS_W'(2)) begin
      words_clamped = WORDS_W'(2);
    end else if (words_raw > WORDS_W'(POOL_WORDS)) begin
      words_clamped = WORDS_W'(POOL_WORDS);
    end
    end_word_next = ADDR_W'(words_clamped - WORDS_W'(1));
  end

  // A header of length zero still advances the walk by one word.
  assign step      = (rd_hdr.len == '0) ? LEN_W'(1) : rd_hdr.len;
  assign npos      = pos + PTR_W'(step);
  assign acc_run   = (in_run ? run : '0) + step;
  assign acc_start = in_run ? run_start : pos[ADDR_W-1:0];
  assign walk_end  = (npos >= PTR_W'(end_word));
  assign fit       = (op_kind == KIND_ALLOC)
                     && ((CMP_W'(req) + CMP_W'(1)) <= CMP_W'(acc_run));
  assign split     = CMP_W'(acc_run) >= (CMP_W'(req) + CMP_W'(2));
  assign pay_words = PTR_W'(acc_start) + PTR_W'(1);
  assign req_sum   = {1'b0, request_bytes} + (BYTES_W+1)'(WORD_BYTES - 1);

  always_comb begin
    state_next              = state;
    in_run_next             = in_run;
    pos_next                = pos;
    run_start_next          = run_start;
    run_next                = run;
    best_next               = best;
    req_next                = req;
    target_next             = target;
    op_kind_next            = op_kind;
    split_addr_next         = split_addr;
    split_len_next          = split_len;
    done_next               = 1'b0;
    status_next             = status;
    payload_offset_next     = payload_offset;
    largest_free_bytes_next = largest_free_bytes;
    wr_en                   = 1'b0;
    wr_addr                 = '0;
    wr_hdr                  = '0;
    rd_addr                 = pos[ADDR_W-1:0];
    best_closed             = best;
    largest_words           = '0;

    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (start) begin
          op_kind_next = kind;
          pos_next     = '0;
          in_run_next  = 1'b0;
          best_next    = '0;
          req_next     = req_sum[BYTES_W:WORD_SHIFT];
          target_next  = block_offset[OFF_W-1:WORD_SHIFT] - ADDR_W'(1);
          if (kind == KIND_ALLOC || kind == KIND_QUERY) begin
            state_next = S_WALK;
          end else if (kind == KIND_FREE) begin
            if (block_offset[WORD_SHIFT-1:0] == '0
                && block_offset[OFF_W-1:WORD_SHIFT] != '0) begin
              state_next = S_FWALK;
            end else begin
              done_next               = 1'b1;
              status_next             = ST_BADFREE;
              payload_offset_next     = '0;
              largest_free_bytes_next = '0;
            end
          end else begin
            done_next               = 1'b1;
            status_next             = ST_OK;
            payload_offset_next     = '0;
            largest_free_bytes_next = '0;
          end
        end
      end

      S_WALK: begin
        if (!rd_hdr.used) begin
          if (fit) begin
            // First fitting run: claim it, whole or split.
            wr_en      = 1'b1;
            wr_addr    = acc_start;
            wr_hdr.used = 1'b1;
            wr_hdr.len = split ? LEN_W'(CMP_W'(req) + CMP_W'(1)) : acc_run;
            status_next             = ST_OK;
            payload_offset_next     = OFF_W'({pay_words, {WORD_SHIFT{1'b0}}});
            largest_free_bytes_next = '0;
            split_addr_next = ADDR_W'(acc_start + req[ADDR_W-1:0] + ADDR_W'(1));
            split_len_next  = acc_run - LEN_W'(req) - LEN_W'(1);
            if (split) begin
              state_next = S_SPLIT;
            end else begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end else if (walk_end) begin
            // Free run reaches the end marker: close it and finish.
            wr_en       = 1'b1;
            wr_addr     = acc_start;
            wr_hdr.used = 1'b0;
            wr_hdr.len  = acc_run;
            best_closed = (acc_run > best) ? acc_run : best;
            best_next   = best_closed;
            state_next  = S_IDLE;
            done_next   = 1'b1;
          end else begin
            in_run_next    = 1'b1;
            run_start_next = acc_start;
            run_next       = acc_run;
            pos_next       = npos;
            rd_addr        = npos[ADDR_W-1:0];
          end
        end else begin
          // An allocated block ends any open free run.
          if (in_run) begin
            wr_en       = 1'b1;
            wr_addr     = run_start;
            wr_hdr.used = 1'b0;
            wr_hdr.len  = run;
            best_closed = (run > best) ? run : best;
          end
          best_next   = best_closed;
          in_run_next = 1'b0;
          if (walk_end) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
          end else begin
            pos_next = npos;
            rd_addr  = npos[ADDR_W-1:0];
          end
        end
        // A walk that ends without a fit; a whole-block fit already holds its result.
        if (done_next && !(fit && !rd_hdr.used)) begin
          largest_words = (best_closed != '0) ? best_closed - LEN_W'(1) : '0;
          status_next   = (op_kind == KIND_ALLOC) ? ST_NOFIT : ST_OK;
          payload_offset_next     = '0;
          largest_free_bytes_next = (op_kind == KIND_QUERY)
                                    ? BYTES_W'({largest_words, {WORD_SHIFT{1'b0}}}) : '0;
        end
      end

      S_SPLIT: begin
        wr_en       = 1'b1;
        wr_addr     = split_addr;
        wr_hdr.used = 1'b0;
        wr_hdr.len  = split_len;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      S_FWALK: begin
        if (pos < PTR_W'(end_word) && pos < PTR_W'(target)) begin
          pos_next = npos;
          rd_addr  = npos[ADDR_W-1:0];
        end else begin
          done_next               = 1'b1;
          state_next              = S_IDLE;
          payload_offset_next     = '0;
          largest_free_bytes_next = '0;
          if (pos == PTR_W'(target) && target < end_word && rd_hdr.used) begin
            wr_en       = 1'b1;
            wr_addr     = target;
            wr_hdr.used = 1'b0;
            wr_hdr.len  = rd_hdr.len;
            status_next = ST_OK;
          end else begin
            status_next = ST_BADFREE;
          end
        end
      end

      S_FMT0: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        wr_hdr.used = 1'b0;
        wr_hdr.len  = LEN_W'(end_word);
        state_next  = S_FMT1;
      end

      S_FMT1: begin
        wr_en       = 1'b1;
        wr_addr     = end_word;
        wr_hdr.used = 1'b1;
        wr_hdr.len  = '0;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A pool size write reformats the pool.
    if (cfg_wr) begin
      state_next = S_FMT0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FMT0;
      in_run     <= 1'b0;
      done       <= 1'b0;
      pool_bytes <= POOL_BYTES_RESET;
      end_word   <= ADDR_W'(POOL_WORDS - 1);
    end else begin
      state  <= state_next;
      in_run <= in_run_next;
      done   <= done_next;
      if (cfg_wr) begin
        pool_bytes <= pwdata[BYTES_W-1:0];
        end_word   <= end_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos                <= pos_next;
    run_start          <= run_start_next;
    run                <= run_next;
    best               <= best_next;
    req                <= req_next;
    target             <= target_next;
    op_kind            <= op_kind_next;
    split_addr         <= split_addr_next;
    split_len          <= split_len_next;
    status             <= status_next;
    payload_offset     <= payload_offset_next;
    largest_free_bytes <= largest_free_bytes_next;
  end

endmodule

`default_nettype wire

// ----- hdl/ffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old contents.
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/ffa_checker.sv -----
// Port-level checker for the first-fit block allocator and its bind statement.
// Depends on ffa_pkg; sees only the top level's ports.
`default_nettype none

module ffa_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [ffa_pkg::KIND_W-1:0]         kind,
  input wire logic [ffa_pkg::BYTES_W-1:0]        request_bytes,
  input wire logic [ffa_pkg::OFF_W-1:0]          block_offset,
  input wire logic                               done,
  input wire logic [ffa_pkg::STATUS_W-1:0]       status,
  input wire logic [ffa_pkg::OFF_W-1:0]          payload_offset,
  input wire logic [ffa_pkg::BYTES_W-1:0]        largest_free_bytes,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pwrite,
  input wire logic [ffa_pkg::CFG_ADDR_W-1:0]     paddr,
  input wire logic [ffa_pkg::CFG_DATA_W-1:0]     pwdata,
  input wire logic [ffa_pkg::CFG_DATA_W-1:0]     prdata,
  input wire logic                               pready
);

  import ffa_pkg::*;

  // A result only follows an accepted command or ongoing work.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result transaction without a command");

  // A failed command carries no offset and no size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (payload_offset == '0 && largest_free_bytes == '0))
    else $error("failed command returned nonzero fields");

  // Offsets and sizes are whole words.
  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (payload_offset[WORD_SHIFT-1:0] == '0
              && largest_free_bytes[WORD_SHIFT-1:0] == '0))
    else $error("result not word aligned");

  // A pool size write starts a reformat, which holds off commands.
  a_cfg_formats: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_POOL_BYTES)
    |=> busy)
    else $error("pool size write did not start a reformat");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

`default_nettype wire

// ----- test/ffa_result_checker.sv -----
// Result checker for the first-fit block allocator: keeps its own mirror of the
// block headers, predicts each command's result and compares the result port.
// Depends on ffa_pkg.
module ffa_result_checker
  import ffa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [BYTES_W-1:0]    request_bytes,
  input  wire logic [OFF_W-1:0]      block_offset,
  input  wire logic                  done,
  input  wire logic [STATUS_W-1:0]   status,
  input  wire logic [OFF_W-1:0]      payload_offset,
  input  wire logic [BYTES_W-1:0]    largest_free_bytes,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic [CFG_DATA_W-1:0] prdata,
  input  wire logic                  pready,
  output int                         errors,
  output int                         pending,
  output int                         placed,
  output int                         nofits,
  output int                         bad_frees,
  output int                         queries
);

  typedef struct {
    kind_t                kind;
    status_t              status;
    logic [OFF_W-1:0]     offset;
    logic [BYTES_W-1:0]   largest;
  } alloc_outcome_t;

  hdr_t               header_mirror [POOL_WORDS];
  logic [ADDR_W-1:0]  end_word;
  logic [BYTES_W-1:0] pool_cfg;
  alloc_outcome_t     awaited_outcomes [$];

  function automatic void format_pool(logic [BYTES_W-1:0] nbytes);
    int words;
    words = int'(nbytes) / WORD_BYTES;
    if (words < 2) words = 2;
    if (words > POOL_WORDS) words = POOL_WORDS;
    foreach (header_mirror[i]) header_mirror[i] = '0;
    end_word = ADDR_W'(words - 1);
    header_mirror[0].len = LEN_W'(words - 1);
    header_mirror[words - 1] = '{used: 1'b1, len: '0};
  endfunction

  // A zero length (the end marker) still advances the walk by one word.
  function automatic int hop(int pos);
    return (header_mirror[pos].len == '0) ? 1 : int'(header_mirror[pos].len);
  endfunction

  // Walks the chain and folds every run of free blocks into its first header.
  // With want set it stops at the first run whose payload holds req words.
  function automatic int merge_free_runs(bit want, int req, output int hit,
                                         output bit found);
    int pos, best, first, run, stride;
    pos = 0;
    best = 0;
    hit = 0;
    found = 1'b0;
    while (pos < int'(end_word)) begin
      if (!header_mirror[pos].used) begin
        first = pos;
        run = 0;
        while (pos < int'(end_word) && !header_mirror[pos].used) begin
          stride = hop(pos);
          run += stride;
          pos += stride;
          if (want && req + 1 <= run) begin
            header_mirror[first].len = LEN_W'(run);
            hit = first;
            found = 1'b1;
            return run;
          end
        end
        header_mirror[first].len = LEN_W'(run);
        if (run > best) best = run;
      end else begin
        pos += hop(pos);
      end
    end
    return best;
  endfunction

  function automatic alloc_outcome_t apply_command(kind_t k, logic [BYTES_W-1:0] nbytes,
                                                   logic [OFF_W-1:0] off);
    alloc_outcome_t r;
    int req, at, run, nxt, h, pos, best;
    bit found;
    r.kind = k;
    r.status = ST_OK;
    r.offset = '0;
    r.largest = '0;
    case (k)
      KIND_ALLOC: begin
        req = (int'(nbytes) + WORD_BYTES - 1) / WORD_BYTES;
        void'(merge_free_runs(1'b1, req, at, found));
        if (!found) begin
          r.status = ST_NOFIT;
        end else begin
          run = int'(header_mirror[at].len);
          if (run >= req + 2) begin
            nxt = at + req + 1;
            header_mirror[at].len = LEN_W'(req + 1);
            if (nxt < POOL_WORDS) header_mirror[nxt] = '{used: 1'b0, len: LEN_W'(run - req - 1)};
          end
          header_mirror[at].used = 1'b1;
          r.offset = OFF_W'((at + 1) * WORD_BYTES);
        end
      end
      KIND_FREE: begin
        found = 1'b0;
        if (int'(off) % WORD_BYTES == 0 && int'(off) >= WORD_BYTES) begin
          h = int'(off) / WORD_BYTES - 1;
          pos = 0;
          while (pos < int'(end_word) && pos < h) pos += hop(pos);
          if (pos == h && h < int'(end_word) && header_mirror[h].used) begin
            header_mirror[h].used = 1'b0;
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_BADFREE;
      end
      KIND_QUERY: begin
        best = merge_free_runs(1'b0, 0, at, found);
        r.largest = (best >= 1) ? BYTES_W'((best - 1) * WORD_BYTES) : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alloc_outcome_t want_r;
    if (rst) begin
      pool_cfg = POOL_BYTES_RESET;
      format_pool(pool_cfg);
      awaited_outcomes.delete();
    end else begin
      // Results first: a command accepted at this edge queues behind them.
      if (done === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status %0d offset %0d largest %0d",
                   $time, status, payload_offset, largest_free_bytes);
        end else begin
          want_r = awaited_outcomes.pop_front();
          if (status !== want_r.status) begin
            errors++;
            $display("%0t: %s status expected %0d, got %0d",
                     $time, want_r.kind.name(), want_r.status, status);
          end
          if (payload_offset !== want_r.offset) begin
            errors++;
            $display("%0t: %s payload_offset expected %0d, got %0d",
                     $time, want_r.kind.name(), want_r.offset, payload_offset);
          end
          if (largest_free_bytes !== want_r.largest) begin
            errors++;
            $display("%0t: %s largest_free_bytes expected %0d, got %0d",
                     $time, want_r.kind.name(), want_r.largest, largest_free_bytes);
          end
        end
      end
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
        if (pwrite === 1'b1) begin
          if (paddr[CFG_ADDR_W-1:2] == REG_POOL_BYTES) begin
            pool_cfg = pwdata[BYTES_W-1:0];
            format_pool(pool_cfg);
          end
        end else if (prdata[BYTES_W-1:0] !== pool_cfg) begin
          errors++;
          $display("%0t: pool_bytes read expected %0d, got %0d",
                   $time, pool_cfg, prdata[BYTES_W-1:0]);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want_r = apply_command(kind_t'(kind), request_bytes, block_offset);
        awaited_outcomes.push_back(want_r);
        if (want_r.kind == KIND_ALLOC && want_r.status == ST_OK) placed++;
        if (want_r.status == ST_NOFIT) nofits++;
        if (want_r.status == ST_BADFREE) bad_frees++;
        if (want_r.kind == KIND_QUERY) queries++;
      end
    end
    pending = awaited_outcomes.size();
  end

endmodule

// ----- test/tb_first_fit_block_allocator.sv -----
// Testbench top for the first-fit block allocator: clock, reset, command and
// register stimulus, and the final verdict. Depends on ffa_pkg, the allocator
// top level and ffa_result_checker.
module tb_first_fit_block_allocator;
  import ffa_pkg::*;

  // The slowest correct run walks a full chain of about a thousand headers for
  // every command and waits out the longest sender gap each time; the limit is
  // several times that.
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int RANDOM_PHASES = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     kind = KIND_NONE;
  logic [BYTES_W-1:0]    request_bytes = '0;
  logic [OFF_W-1:0]      block_offset = '0;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [OFF_W-1:0]      payload_offset;
  logic [BYTES_W-1:0]    largest_free_bytes;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int errors, pending, placed, nofits, bad_frees, queries;
  int cycle_count = 0;
  int items_sent = 0;
  int pool_settings = 1;

  // Payload offsets handed out and not yet freed, so that most frees name a
  // real block. The last freed offset feeds deliberate double frees.
  logic [OFF_W-1:0] live_offsets [$];
  logic [OFF_W-1:0] last_freed = '0;

  first_fit_block_allocator DUT (.*);

  ffa_result_checker result_check (.*);

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Track successful allocations from the result port. Only an allocate that
  // placed a block returns a nonzero payload offset.
  always @(posedge clk) begin
    if (!rst && done === 1'b1 && payload_offset != '0) live_offsets.push_back(payload_offset);
  end

  // Present one command transaction and hold it until the block takes it,
  // which is the first rising edge with busy low.
  task automatic issue(kind_t k, logic [BYTES_W-1:0] nbytes, logic [OFF_W-1:0] off);
    @(negedge clk);
    start = 1'b1;
    kind = k;
    request_bytes = nbytes;
    block_offset = off;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Leave start low for a gap given by n. The operand ports carry junk meanwhile, which
  // the block has to ignore.
  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      kind = KIND_W'($urandom);
      request_bytes = BYTES_W'($urandom);
      block_offset = OFF_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back and the
  // block has gone idle, including a trailing split write.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write pool_bytes, which reformats the pool, then read it back so that the
  // checker can compare the register value.
  task automatic program_pool(int nbytes);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_POOL_BYTES, 2'b00};
    pwdata = CFG_DATA_W'(nbytes);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    live_offsets.delete();
    last_freed = '0;
    pool_settings++;
  endtask

  initial begin : stimulus
    int p, pool, words, phase_items, sel, idx, gap;
    bit no_gaps;
    logic [BYTES_W-1:0] nbytes;
    logic [OFF_W-1:0] off;

    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed part on the reset pool of 1024 words. The offsets follow the
    // layout that these commands build up from the start of the pool.
    issue(KIND_QUERY, 0, 0);         // one free block spanning the whole pool
    issue(KIND_ALLOC, 0, 0);         // zero bytes gives a header-only block
    issue(KIND_ALLOC, 1, 0);         // one byte rounds up to a word
    issue(KIND_ALLOC, 16, 0);
    issue(KIND_ALLOC, 8, 0);
    issue(KIND_FREE, 0, 32);         // frees the three-word block
    issue(KIND_ALLOC, 8, 0);         // split leaves a header-only free block
    issue(KIND_ALLOC, 0, 0);         // which a zero-byte request takes whole
    issue(KIND_FREE, 0, 48);
    issue(KIND_FREE, 0, 48);         // second free of the same block
    issue(KIND_FREE, 0, 16);
    issue(KIND_FREE, 0, 32);         // three neighbors are free now
    issue(KIND_ALLOC, 32, 0);        // only fits once they are merged; no split
    issue(KIND_FREE, 0, 20);         // not word aligned
    issue(KIND_FREE, 0, 0);          // below the first payload
    issue(KIND_FREE, 0, 24);         // inside a block, not after a header
    issue(KIND_FREE, 0, 8191);
    issue(KIND_NONE, 14'h3fff, 13'h1fff);
    issue(KIND_ALLOC, 8192, 0);      // more than the whole pool
    issue(KIND_ALLOC, 16383, 0);
    issue(KIND_ALLOC, 8160, 0);      // more than what is left
    issue(KIND_QUERY, 14'h3fff, 13'h1fff);
    issue(KIND_FREE, 0, 8);
    issue(KIND_QUERY, 0, 0);
    settle();

    // Random phases, each on a fresh pool. The first few hit the smallest and
    // largest sizes, sizes outside the legal range and a size that is not a
    // whole number of words.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       pool = 16;
        1:       pool = 8192;
        2:       pool = 0;
        3:       pool = 16383;
        4:       pool = 100;
        5:       pool = 1024;
        default: pool = $urandom_range(16, 8192);
      endcase
      program_pool(pool);
      words = pool / WORD_BYTES;
      if (words < 2) words = 2;
      if (words > POOL_WORDS) words = POOL_WORDS;
      phase_items = (words <= 4) ? 40 : 190;
      no_gaps = ($urandom_range(0, 3) == 0);

      repeat (phase_items) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          // Mostly small blocks so that the chain grows long, with some large
          // requests that drive the pool into no-fit territory.
          idx = $urandom_range(0, 9);
          if (idx < 6) nbytes = BYTES_W'($urandom_range(0, 64));
          else if (idx < 9) nbytes = BYTES_W'($urandom_range(0, words * WORD_BYTES / 3));
          else nbytes = BYTES_W'($urandom);
          issue(KIND_ALLOC, nbytes, OFF_W'($urandom));
        end else if (sel < 82) begin
          if (live_offsets.size() != 0 && $urandom_range(0, 9) < 8) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[idx];
            live_offsets.delete(idx);
            last_freed = off;
          end else if ($urandom_range(0, 1) == 1) begin
            off = last_freed;
          end else begin
            off = OFF_W'($urandom_range(0, words) * WORD_BYTES);
          end
          issue(KIND_FREE, BYTES_W'($urandom), off);
        end else if (sel < 92) begin
          issue(KIND_QUERY, BYTES_W'($urandom), OFF_W'($urandom));
        end else if (sel < 96) begin
          issue(KIND_NONE, BYTES_W'($urandom), OFF_W'($urandom));
        end else begin
          issue(KIND_FREE, BYTES_W'($urandom), OFF_W'($urandom));
        end

        // Sender gaps: mostly none or short, now and then long, and rarely a
        // full pause until the block has answered everything.
        if ($urandom_range(0, 59) == 0) begin
          settle();
        end else if (!no_gaps) begin
          gap = $urandom_range(0, 19);
          if (gap < 11) idle_for(0);
          else if (gap < 18) idle_for($urandom_range(1, 3));
          else idle_for($urandom_range(10, 40));
        end
      end
      settle();
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d commands over %0d pool sizes, out-of-range sizes included.",
             items_sent, pool_settings);
    $display("Placed %0d blocks, %0d requests without a fit, %0d rejected frees, %0d queries.",
             placed, nofits, bad_frees, queries);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
